// ----- sv/kdpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kdpc_pkg
// Shared types and constants for the key debounce and press classifier.
// ----------------------------------------------------------------------------
package kdpc_pkg;

  localparam int unsigned NUM_KEYS  = 3;
  localparam int unsigned RAW_W     = 3;
  localparam int unsigned MASK_W    = 3;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;

  localparam logic [TIME_W-1:0]   PRESS_CAP          = 16'd60000;
  localparam logic [TIME_W-1:0]   TIME_MAX           = 16'hFFFF;
  localparam logic [TIME_W-1:0]   DEBOUNCE_RESET     = 16'd20;
  localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET  = 8'd10;
  localparam logic [TIME_W-1:0]   LONG_PRESS_RESET   = 16'd1000;
  localparam logic [TIME_W-1:0]   STARTUP_IGN_RESET  = 16'd500;
  localparam logic                ACTIVE_LEVEL_RESET = 1'b0;
  localparam logic                INACTIVE_AT_RESET  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TIME       = 3'd0,
    CFG_SCAN_PERIOD         = 3'd1,
    CFG_LONG_PRESS_TIME     = 3'd2,
    CFG_STARTUP_IGNORE_TIME = 3'd3,
    CFG_ACTIVE_LEVEL        = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    REQ_SCAN    = 1'b0,
    REQ_RESTART = 1'b1
  } req_type_e;

endpackage

`default_nettype wire

// ----- sv/key_debounce_press_classifier.sv -----
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle unless the result side stalls, set by the
//   single pass from the input register through the per-key update logic
//   into the result register
// reset: asynchronous, clears config to defaults, keys to inactive,
//   startup ignore countdown to 500 and both pipeline stages to empty
// ----------------------------------------------------------------------------
// key_debounce_press_classifier
// Debounces three keys per scan tick and reports short and long presses,
// with a startup ignore countdown and an all-released arming step.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier
  import kdpc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 req_type_i,
  input  wire logic [RAW_W-1:0]     raw_levels_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [MASK_W-1:0]         short_press_mask_o,
  output logic [MASK_W-1:0]         long_press_mask_o,
  output logic                      input_armed_o
);

  // configuration
  logic [TIME_W-1:0]   debounce_time_q;
  logic [PERIOD_W-1:0] scan_period_q;
  logic [TIME_W-1:0]   long_press_time_q;
  logic [TIME_W-1:0]   startup_ignore_time_q;
  logic                active_level_q;

  // input stage
  logic               in_valid_q;
  logic               req_type_q;
  logic [RAW_W-1:0]   raw_levels_q;
  logic               advance;
  logic               in_accept;

  // key state
  logic [NUM_KEYS-1:0] stable_q, stable_d;
  logic [NUM_KEYS-1:0] prev_q, prev_d;
  logic [TIME_W-1:0]   hold_q [NUM_KEYS];
  logic [TIME_W-1:0]   hold_d [NUM_KEYS];
  logic [TIME_W-1:0]   press_q [NUM_KEYS];
  logic [TIME_W-1:0]   press_d [NUM_KEYS];
  logic [NUM_KEYS-1:0] short_rep_q, short_rep_d;
  logic [NUM_KEYS-1:0] long_rep_q, long_rep_d;
  logic [TIME_W-1:0]   ignore_q, ignore_d;
  logic [TIME_W-1:0]   confirm_q, confirm_d;
  logic                armed_q, armed_d;

  logic [NUM_KEYS-1:0] raw_ext;
  logic [NUM_KEYS-1:0] ev_short, ev_long;
  logic [MASK_W-1:0]   smask_d, lmask_d;

  // result stage
  logic                out_valid_q;
  logic [MASK_W-1:0]   smask_q, lmask_q;
  logic                armed_out_q;

  assign advance   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_time_q       <= DEBOUNCE_RESET;
      scan_period_q         <= SCAN_PERIOD_RESET;
      long_press_time_q     <= LONG_PRESS_RESET;
      startup_ignore_time_q <= STARTUP_IGN_RESET;
      active_level_q        <= ACTIVE_LEVEL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEBOUNCE_TIME:       debounce_time_q       <= cfg_data_i;
        CFG_SCAN_PERIOD:         scan_period_q         <= cfg_data_i[PERIOD_W-1:0];
        CFG_LONG_PRESS_TIME:     long_press_time_q     <= cfg_data_i;
        CFG_STARTUP_IGNORE_TIME: startup_ignore_time_q <= cfg_data_i;
        CFG_ACTIVE_LEVEL:        active_level_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_type_q   <= req_type_i;
      raw_levels_q <= raw_levels_i;
    end
  end

  // keys beyond the raw field read as zero
  always_comb begin
    raw_ext = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (k < RAW_W) begin
        raw_ext[k] = raw_levels_q[k];
      end
    end
  end

  always_comb begin
    logic                 s;
    logic                 none_active;
    logic [TIME_W:0]      sum;
    logic [TIME_W-1:0]    pd;
    logic [TIME_W:0]      psum;

    stable_d    = stable_q;
    prev_d      = prev_q;
    short_rep_d = short_rep_q;
    long_rep_d  = long_rep_q;
    ignore_d    = ignore_q;
    confirm_d   = confirm_q;
    armed_d     = armed_q;
    ev_short    = '0;
    ev_long     = '0;
    none_active = 1'b1;
    s           = 1'b0;
    sum         = '0;
    pd          = '0;
    psum        = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      hold_d[k]  = hold_q[k];
      press_d[k] = press_q[k];
    end

    if (req_type_q == REQ_RESTART || ignore_q != '0 || !armed_q) begin
      // resync every key to its raw level
      stable_d    = raw_ext;
      prev_d      = raw_ext;
      short_rep_d = '0;
      long_rep_d  = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_d[k]  = '0;
        press_d[k] = '0;
      end
      if (req_type_q == REQ_RESTART) begin
        ignore_d  = startup_ignore_time_q;
        confirm_d = '0;
        armed_d   = 1'b0;
      end else if (ignore_q != '0) begin
        if (ignore_q > {8'd0, scan_period_q}) begin
          ignore_d = ignore_q - {8'd0, scan_period_q};
        end else begin
          ignore_d = '0;
        end
        confirm_d = '0;
      end else begin
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (raw_ext[k] == active_level_q) begin
            none_active = 1'b0;
          end
        end
        if (none_active) begin
          confirm_d = confirm_q;
          if (confirm_q < debounce_time_q) begin
            sum = {1'b0, confirm_q} + {9'd0, scan_period_q};
            confirm_d = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          end
          if (confirm_d >= debounce_time_q) begin
            armed_d = 1'b1;
          end
        end else begin
          confirm_d = '0;
        end
      end
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        s = raw_ext[k];
        if (s == prev_q[k]) begin
          if (hold_q[k] < debounce_time_q) begin
            sum = {1'b0, hold_q[k]} + {9'd0, scan_period_q};
            hold_d[k] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
          end else begin
            stable_d[k] = s;
          end
        end else begin
          hold_d[k] = '0;
          prev_d[k] = s;
          if (s != active_level_q) begin
            stable_d[k] = s;
          end
        end
        if (stable_d[k] == active_level_q) begin
          pd = press_q[k];
          if (press_q[k] < PRESS_CAP) begin
            psum = {1'b0, press_q[k]} + {9'd0, scan_period_q};
            pd = (psum > {1'b0, PRESS_CAP}) ? PRESS_CAP : psum[TIME_W-1:0];
          end
          press_d[k] = pd;
          if (!short_rep_q[k]) begin
            ev_short[k]    = 1'b1;
            short_rep_d[k] = 1'b1;
          end
          if (pd >= long_press_time_q && !long_rep_q[k]) begin
            ev_short[k]   = 1'b0;
            ev_long[k]    = 1'b1;
            long_rep_d[k] = 1'b1;
          end
        end else begin
          press_d[k]     = '0;
          long_rep_d[k]  = 1'b0;
          short_rep_d[k] = 1'b0;
        end
      end
    end
  end

  // mask bits beyond the output width are dropped
  always_comb begin
    smask_d = '0;
    lmask_d = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (i < MASK_W) begin
        smask_d[i] = ev_short[i];
        lmask_d[i] = ev_long[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q    <= {NUM_KEYS{INACTIVE_AT_RESET}};
      prev_q      <= {NUM_KEYS{INACTIVE_AT_RESET}};
      short_rep_q <= '0;
      long_rep_q  <= '0;
      ignore_q    <= STARTUP_IGN_RESET;
      confirm_q   <= '0;
      armed_q     <= 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_q[k]  <= '0;
        press_q[k] <= '0;
      end
    end else if (advance) begin
      stable_q    <= stable_d;
      prev_q      <= prev_d;
      short_rep_q <= short_rep_d;
      long_rep_q  <= long_rep_d;
      ignore_q    <= ignore_d;
      confirm_q   <= confirm_d;
      armed_q     <= armed_d;
      for (int k = 0; k < NUM_KEYS; k++) begin
        hold_q[k]  <= hold_d[k];
        press_q[k] <= press_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      smask_q     <= smask_d;
      lmask_q     <= lmask_d;
      armed_out_q <= armed_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign short_press_mask_o = smask_q;
  assign long_press_mask_o  = lmask_q;
  assign input_armed_o      = armed_out_q;

endmodule

`default_nettype wire

// ----- sim/key_debounce_press_classifier_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_press_classifier_test
// Self-checking bench for the key debounce and press classifier. A short
// directed table walks the countdown, arming, short and long presses and the
// register corner values. Random phases then run press and release patterns
// with bounce noise and restarts under several register settings. Every
// result is checked field by field against the table or a local model, with
// random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module key_debounce_press_classifier_test;
  import kdpc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned END_CYCLES    = 8;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned PRINT_LIMIT   = 40;

  typedef struct packed {
    logic [MASK_W-1:0] short_mask;
    logic [MASK_W-1:0] long_mask;
    logic              armed;
  } press_result_t;

  typedef struct packed {
    logic              is_cfg;
    cfg_reg_e          reg_idx;
    logic [CFG_W-1:0]  value;
    req_type_e         req;
    logic [RAW_W-1:0]  raw;
    logic              typed;
    press_result_t     want;
  } step_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i = 1'b0;
  logic [RAW_W-1:0]     raw_levels_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [MASK_W-1:0]    short_press_mask_o;
  logic [MASK_W-1:0]    long_press_mask_o;
  logic                 input_armed_o;

  // model configuration
  logic [TIME_W-1:0]    cfg_debounce;
  logic [PERIOD_W-1:0]  cfg_period;
  logic [TIME_W-1:0]    cfg_long;
  logic [TIME_W-1:0]    cfg_startup;
  logic                 cfg_active_level;

  // model key state
  logic [NUM_KEYS-1:0]  key_stable;
  logic [NUM_KEYS-1:0]  key_prev;
  logic [NUM_KEYS-1:0]  short_done;
  logic [NUM_KEYS-1:0]  long_done;
  logic [TIME_W-1:0]    key_hold [NUM_KEYS];
  logic [TIME_W-1:0]    key_press [NUM_KEYS];
  logic [TIME_W-1:0]    ignore_left;
  logic [TIME_W-1:0]    release_time;
  logic                 armed_q;

  press_result_t        awaited_events [$];
  press_result_t        monitor_want;
  step_row_t            directed [$];
  int unsigned          mismatch_count = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          src_calm = 0;
  int unsigned          sink_calm = 0;
  int unsigned          stall_left = 0;

  key_debounce_press_classifier dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .raw_levels_i       (raw_levels_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .short_press_mask_o (short_press_mask_o),
    .long_press_mask_o  (long_press_mask_o),
    .input_armed_o      (input_armed_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [PERIOD_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = a + b;
    return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  function automatic void resync_keys(input logic [RAW_W-1:0] raw);
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_stable[k] = raw[k];
      key_prev[k]   = raw[k];
      key_hold[k]   = '0;
      key_press[k]  = '0;
      short_done[k] = 1'b0;
      long_done[k]  = 1'b0;
    end
  endfunction

  function automatic void reset_model();
    cfg_debounce     = DEBOUNCE_RESET;
    cfg_period       = SCAN_PERIOD_RESET;
    cfg_long         = LONG_PRESS_RESET;
    cfg_startup      = STARTUP_IGN_RESET;
    cfg_active_level = ACTIVE_LEVEL_RESET;
    resync_keys({RAW_W{INACTIVE_AT_RESET}});
    ignore_left  = STARTUP_IGN_RESET;
    release_time = '0;
    armed_q      = 1'b0;
  endfunction

  function automatic press_result_t classify_scan(input req_type_e req,
                                                  input logic [RAW_W-1:0] raw);
    press_result_t   res;
    logic [TIME_W:0] grown;
    res = '0;
    if (req == REQ_RESTART) begin
      ignore_left  = cfg_startup;
      release_time = '0;
      armed_q      = 1'b0;
      resync_keys(raw);
    end else if (ignore_left != '0) begin
      ignore_left  = (ignore_left > cfg_period) ? ignore_left - cfg_period : '0;
      release_time = '0;
      resync_keys(raw);
    end else if (!armed_q) begin
      resync_keys(raw);
      if ((raw ~^ {RAW_W{cfg_active_level}}) == '0) begin
        if (release_time < cfg_debounce) release_time = sat_add(release_time, cfg_period);
        if (release_time >= cfg_debounce) armed_q = 1'b1;
      end else begin
        release_time = '0;
      end
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (raw[k] == key_prev[k]) begin
          if (key_hold[k] < cfg_debounce) key_hold[k] = sat_add(key_hold[k], cfg_period);
          else key_stable[k] = raw[k];
        end else begin
          key_hold[k] = '0;
          key_prev[k] = raw[k];
          if (raw[k] != cfg_active_level) key_stable[k] = raw[k];
        end
        if (key_stable[k] == cfg_active_level) begin
          if (key_press[k] < PRESS_CAP) begin
            grown = key_press[k] + cfg_period;
            key_press[k] = (grown > PRESS_CAP) ? PRESS_CAP : grown[TIME_W-1:0];
          end
          if (!short_done[k]) begin
            res.short_mask[k] = 1'b1;
            short_done[k]     = 1'b1;
          end
          // long press displaces a short press on the same tick
          if (key_press[k] >= cfg_long && !long_done[k]) begin
            res.short_mask[k] = 1'b0;
            res.long_mask[k]  = 1'b1;
            long_done[k]      = 1'b1;
          end
        end else begin
          key_press[k]  = '0;
          short_done[k] = 1'b0;
          long_done[k]  = 1'b0;
        end
      end
    end
    res.armed = armed_q;
    return res;
  endfunction

  function automatic int unsigned pick_gap(inout int unsigned calm_left);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if (roll < 2) begin
      calm_left = $urandom_range(20, 100);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic step_row_t row_item(input req_type_e req, input logic [RAW_W-1:0] raw);
    step_row_t r;
    r     = '0;
    r.req = req;
    r.raw = raw;
    return r;
  endfunction

  function automatic step_row_t row_typed(input req_type_e req, input logic [RAW_W-1:0] raw,
                                          input logic [MASK_W-1:0] s, input logic [MASK_W-1:0] l,
                                          input logic a);
    step_row_t r;
    r       = row_item(req, raw);
    r.typed = 1'b1;
    r.want  = '{short_mask: s, long_mask: l, armed: a};
    return r;
  endfunction

  function automatic step_row_t row_cfg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    step_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.value   = val;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      CFG_DEBOUNCE_TIME:       cfg_debounce     = val;
      CFG_SCAN_PERIOD:         cfg_period       = val[PERIOD_W-1:0];
      CFG_LONG_PRESS_TIME:     cfg_long         = val;
      CFG_STARTUP_IGNORE_TIME: cfg_startup      = val;
      CFG_ACTIVE_LEVEL:        cfg_active_level = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input req_type_e req, input logic [RAW_W-1:0] raw,
                           input logic typed, input press_result_t want);
    press_result_t predicted;
    int unsigned   gap;
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    raw_levels_i <= raw;
    predicted = classify_scan(req, raw);
    awaited_events.push_back(typed ? want : predicted);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    gap = pick_gap(src_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // block idle before any register write
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] db, input logic [PERIOD_W-1:0] sp,
                           input logic [TIME_W-1:0] lp, input logic [TIME_W-1:0] si,
                           input logic al, input logic restart_first,
                           input int unsigned noise_pm, input int unsigned min_run,
                           input int unsigned max_run, input int unsigned count);
    logic [NUM_KEYS-1:0] held;
    int unsigned         run_left [NUM_KEYS];
    logic [RAW_W-1:0]    raw;
    req_type_e           req;
    settle();
    write_reg(CFG_DEBOUNCE_TIME, db);
    write_reg(CFG_SCAN_PERIOD, {{(CFG_W-PERIOD_W){1'b0}}, sp});
    write_reg(CFG_LONG_PRESS_TIME, lp);
    write_reg(CFG_STARTUP_IGNORE_TIME, si);
    write_reg(CFG_ACTIVE_LEVEL, {{(CFG_W-1){1'b0}}, al});
    held = '0;
    for (int k = 0; k < NUM_KEYS; k++) run_left[k] = $urandom_range(min_run, max_run);
    if (restart_first) send_item(REQ_RESTART, RAW_W'($urandom_range(0, 7)), 1'b0, '0);
    repeat (count) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (run_left[k] == 0) begin
          held[k]     = ~held[k];
          run_left[k] = $urandom_range(min_run, max_run);
        end else begin
          run_left[k]--;
        end
      end
      // keep keys released until armed so the arming step can complete
      if (!armed_q) raw = {RAW_W{~cfg_active_level}};
      else raw = cfg_active_level ? held : ~held;
      for (int k = 0; k < RAW_W; k++)
        if ($urandom_range(0, 999) < noise_pm) raw[k] = ~raw[k];
      req = ($urandom_range(0, 255) == 0) ? REQ_RESTART : REQ_SCAN;
      send_item(req, raw, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_gap(sink_calm);
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_events.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        monitor_want = awaited_events.pop_front();
        if (short_press_mask_o !== monitor_want.short_mask)
          report_mismatch($sformatf("short_press_mask %b, expected %b",
                                    short_press_mask_o, monitor_want.short_mask));
        if (long_press_mask_o !== monitor_want.long_mask)
          report_mismatch($sformatf("long_press_mask %b, expected %b",
                                    long_press_mask_o, monitor_want.long_mask));
        if (input_armed_o !== monitor_want.armed)
          report_mismatch($sformatf("input_armed %b, expected %b",
                                    input_armed_o, monitor_want.armed));
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    reset_model();
    directed = '{
      row_typed(REQ_SCAN, 3'd7, 3'd0, 3'd0, 1'b0),
      row_cfg(CFG_SCAN_PERIOD, 16'd255),
      row_typed(REQ_SCAN, 3'd0, 3'd0, 3'd0, 1'b0),
      row_typed(REQ_SCAN, 3'd5, 3'd0, 3'd0, 1'b0),
      row_typed(REQ_SCAN, 3'd0, 3'd0, 3'd0, 1'b0),
      row_typed(REQ_SCAN, 3'd7, 3'd0, 3'd0, 1'b1),
      row_item(REQ_SCAN, 3'd6),
      row_item(REQ_SCAN, 3'd6),
      row_item(REQ_SCAN, 3'd6),
      row_item(REQ_SCAN, 3'd6),
      row_item(REQ_SCAN, 3'd6),
      row_item(REQ_SCAN, 3'd6),
      row_item(REQ_SCAN, 3'd7),
      row_typed(REQ_RESTART, 3'd0, 3'd0, 3'd0, 1'b0),
      row_cfg(CFG_DEBOUNCE_TIME, 16'd0),
      row_cfg(CFG_LONG_PRESS_TIME, 16'd0),
      row_cfg(CFG_STARTUP_IGNORE_TIME, 16'd0),
      row_typed(REQ_RESTART, 3'd7, 3'd0, 3'd0, 1'b0),
      row_typed(REQ_SCAN, 3'd7, 3'd0, 3'd0, 1'b1),
      row_item(REQ_SCAN, 3'd0),
      row_typed(REQ_SCAN, 3'd0, 3'd0, 3'd7, 1'b1),
      row_cfg(CFG_ACTIVE_LEVEL, 16'd1),
      row_item(REQ_SCAN, 3'd0),
      row_item(REQ_SCAN, 3'd7),
      row_typed(REQ_SCAN, 3'd7, 3'd0, 3'd7, 1'b1),
      row_cfg(CFG_SCAN_PERIOD, 16'd0),
      row_typed(REQ_RESTART, 3'd2, 3'd0, 3'd0, 1'b0),
      row_typed(REQ_SCAN, 3'd5, 3'd0, 3'd0, 1'b0),
      row_typed(REQ_SCAN, 3'd0, 3'd0, 3'd0, 1'b1),
      row_item(REQ_SCAN, 3'd1),
      row_item(REQ_SCAN, 3'd1),
      row_cfg(CFG_STARTUP_IGNORE_TIME, 16'd100),
      row_typed(REQ_RESTART, 3'd0, 3'd0, 3'd0, 1'b0),
      row_typed(REQ_SCAN, 3'd3, 3'd0, 3'd0, 1'b0)
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_reg(directed[i].reg_idx, directed[i].value);
      end else begin
        send_item(directed[i].req, directed[i].raw, directed[i].typed, directed[i].want);
      end
    end

    //        debounce scan  long    startup active rst noise run     items
    run_phase(16'd20,    8'd10,  16'd200,   16'd50,    1'b0, 1'b1, 30, 1,   40,  300);
    run_phase(16'd0,     8'd1,   16'd0,     16'd0,     1'b1, 1'b1, 50, 1,   10,  150);
    run_phase(16'd65535, 8'd255, 16'd60000, 16'd0,     1'b0, 1'b1, 0,  300, 700, 700);
    run_phase(16'd0,     8'd0,   16'd0,     16'd0,     1'b1, 1'b1, 50, 1,   8,   100);
    run_phase(16'd500,   8'd255, 16'd60000, 16'd65535, 1'b0, 1'b1, 10, 1,   400, 500);
    run_phase(16'd40,    8'd13,  16'd300,   16'd100,   1'b1, 1'b0, 20, 1,   60,  200);

    settle();
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- key_debounce_press_classifier.f -----
sv/kdpc_pkg.sv
sv/key_debounce_press_classifier.sv
sim/key_debounce_press_classifier_test.sv
